// File: hw/rtl/modular_exponentiation_macros.svh
// ----------------------------------------------------------------------------
// modular exponentiation assertion macros
// shared concurrent assertion forms for the modular exponentiation block
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH

// antecedent implies consequent in the same cycle
`define MODEXP_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("modexp assertion failed");

// antecedent implies consequent in the next cycle
`define MODEXP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("modexp assertion failed");

`endif

// File: hw/rtl/modexp_pkg.sv
// ----------------------------------------------------------------------------
// modexp_pkg
// shared types and register indexes of the modular exponentiation block
// ----------------------------------------------------------------------------
package modexp_pkg;

   // configuration register indexes
   typedef enum logic [0:0] {
      CFG_EXPONENT = 1'b0,
      CFG_MODULUS  = 1'b1
   } cfg_index_type;

   // status of the serial modular multiplier
   typedef struct packed {
      logic busy;
      logic done;
   } mm_status_type;

endpackage

// File: hw/rtl/modexp_mulmod.sv
// ----------------------------------------------------------------------------
// modexp_mulmod
// bit-serial add-and-double modular multiplier, one bit of b per cycle
// ----------------------------------------------------------------------------
module modexp_mulmod #(
   parameter int WORD_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [WORD_BITS-1:0]         a,        // must be below m
   input  logic [WORD_BITS-1:0]         b,
   input  logic [WORD_BITS-1:0]         m,        // nonzero, held during the run
   output modexp_pkg::mm_status_type    status,
   output logic [WORD_BITS-1:0]         result
);

   localparam int CNT_BITS = $clog2(WORD_BITS + 1);

   logic [WORD_BITS-1:0] acc_ff, acc_in;
   logic [WORD_BITS-1:0] a_ff, a_in;
   logic [WORD_BITS-1:0] b_ff, b_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   logic [WORD_BITS:0]   dbl;
   logic [WORD_BITS-1:0] dbl_red;
   logic [WORD_BITS:0]   sum;
   logic [WORD_BITS-1:0] sum_red;
   logic [WORD_BITS:0]   m_ext;

   // one step: acc = 2*acc mod m, then add a when the current bit of b is set
   always_comb begin
      m_ext   = {1'b0, m};
      dbl     = {acc_ff, 1'b0};
      dbl_red = (dbl >= m_ext) ? WORD_BITS'(dbl - m_ext) : dbl[WORD_BITS-1:0];
      sum     = {1'b0, dbl_red} + (b_ff[WORD_BITS-1] ? {1'b0, a_ff} : '0);
      sum_red = (sum >= m_ext) ? WORD_BITS'(sum - m_ext) : sum[WORD_BITS-1:0];
   end

   always_comb begin
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = '0;
         a_in    = a;
         b_in    = b;
         cnt_in  = CNT_BITS'(WORD_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = sum_red;
         b_in   = {b_ff[WORD_BITS-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign result      = acc_ff;

endmodule

// File: hw/rtl/modular_exponentiation.sv
// run: one modular product reduces the base, then each exponent bit takes a square, and a multiply when the bit is set
// throughput: one word at a time; the next word is taken once the last one is offered
// the products are computed one after another by the bit-serial multiplier
// zero exponent gives 1, zero modulus gives 0, without running the multiplier
// reset: synchronous, active high; exponent and modulus return to 1, pipeline empties
// ----------------------------------------------------------------------------
// modular_exponentiation
// ciphertext ^ exponent mod modulus by msb-first square-and-multiply
// ----------------------------------------------------------------------------
`include "modular_exponentiation_macros.svh"

module modular_exponentiation #(
   parameter int WORD_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [((WORD_BITS+7)/8)*8-1:0]      req_tdata,   // ciphertext
   // response channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [((WORD_BITS+7)/8)*8-1:0]      rsp_tdata,   // plaintext
   // configuration
   input  logic                                csr_wen,
   input  logic [0:0]                          csr_index,
   input  logic [WORD_BITS-1:0]                csr_wdata
);

   localparam int TDATA_BITS = ((WORD_BITS + 7) / 8) * 8;
   localparam int BIT_BITS   = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_SQUARE,
      ST_MULT,
      ST_FINISH
   } state_type;

   state_type            state_ff, state_in;
   logic [WORD_BITS-1:0] exponent_ff, exponent_in;
   logic [WORD_BITS-1:0] modulus_ff, modulus_in;
   logic [WORD_BITS-1:0] exp_sh_ff, exp_sh_in;
   logic [WORD_BITS-1:0] base_ff, base_in;
   logic [WORD_BITS-1:0] acc_ff, acc_in;
   logic [BIT_BITS-1:0]  bit_ff, bit_in;
   logic                 start_ff, start_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [WORD_BITS-1:0] rsp_data_ff, rsp_data_in;

   logic [WORD_BITS-1:0]      one_mod;
   logic [WORD_BITS-1:0]      mm_a, mm_b;
   logic [WORD_BITS-1:0]      mm_result;
   modexp_pkg::mm_status_type mm_status;
   logic                      req_fire;
   logic                      in_run;
   logic                      in_loop;
   logic                      operands_reduced;

   assign one_mod  = (modulus_ff == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);
   assign req_fire = req_tvalid && req_tready;

   // operand select: reduction of the base is base * 1 with the bits of the base serial
   always_comb begin
      unique case (state_ff)
         ST_REDUCE: begin
            mm_a = one_mod;
            mm_b = base_ff;
         end
         ST_MULT: begin
            mm_a = base_ff;
            mm_b = acc_ff;
         end
         default: begin
            mm_a = acc_ff;
            mm_b = acc_ff;
         end
      endcase
   end

   modexp_mulmod #(
      .WORD_BITS (WORD_BITS)
   ) u_mulmod (
      .clock  (clock),
      .reset  (reset),
      .start  (start_ff),
      .a      (mm_a),
      .b      (mm_b),
      .m      (modulus_ff),
      .status (mm_status),
      .result (mm_result)
   );

   always_comb begin
      state_in     = state_ff;
      exponent_in  = exponent_ff;
      modulus_in   = modulus_ff;
      exp_sh_in    = exp_sh_ff;
      base_in      = base_ff;
      acc_in       = acc_ff;
      bit_in       = bit_ff;
      start_in     = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_wen) begin
         unique case (modexp_pkg::cfg_index_type'(csr_index))
            modexp_pkg::CFG_EXPONENT: exponent_in = csr_wdata;
            modexp_pkg::CFG_MODULUS:  modulus_in  = csr_wdata;
            default:                  ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               base_in   = req_tdata[WORD_BITS-1:0];
               exp_sh_in = exponent_ff;
               bit_in    = BIT_BITS'(WORD_BITS - 1);
               if (exponent_ff == '0) begin
                  acc_in   = WORD_BITS'(1);
                  state_in = ST_FINISH;
               end else if (modulus_ff == '0) begin
                  acc_in   = '0;
                  state_in = ST_FINISH;
               end else begin
                  start_in = 1'b1;
                  state_in = ST_REDUCE;
               end
            end
         end
         ST_REDUCE: begin
            if (mm_status.done) begin
               base_in  = mm_result;
               acc_in   = one_mod;
               start_in = 1'b1;
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE, ST_MULT: begin
            if (mm_status.done) begin
               acc_in = mm_result;
               if (state_ff == ST_SQUARE && exp_sh_ff[WORD_BITS-1]) begin
                  start_in = 1'b1;
                  state_in = ST_MULT;
               end else begin
                  // move on to the next exponent bit
                  exp_sh_in = exp_sh_ff << 1;
                  if (bit_ff == '0) begin
                     state_in = ST_FINISH;
                  end else begin
                     bit_in   = bit_ff - BIT_BITS'(1);
                     start_in = 1'b1;
                     state_in = ST_SQUARE;
                  end
               end
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = acc_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         exponent_ff  <= WORD_BITS'(1);
         modulus_ff   <= WORD_BITS'(1);
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         exponent_ff  <= exponent_in;
         modulus_ff   <= modulus_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      exp_sh_ff   <= exp_sh_in;
      base_ff     <= base_in;
      acc_ff      <= acc_in;
      bit_ff      <= bit_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = TDATA_BITS'(rsp_data_ff);

   assign in_loop          = (state_ff == ST_SQUARE) || (state_ff == ST_MULT);
   assign in_run           = in_loop || (state_ff == ST_REDUCE);
   assign operands_reduced = (acc_ff < modulus_ff) && (base_ff < modulus_ff);

   `MODEXP_ASSERT_IMP(a_done_in_run, clock, reset, mm_status.done, in_run)
   `MODEXP_ASSERT_IMP(a_acc_reduced, clock, reset, in_loop, operands_reduced)
   `MODEXP_ASSERT_NEXT(a_start_runs, clock, reset, start_ff, (mm_status.busy && !mm_status.done))

endmodule
